@@ rtl/core/hhlv_pkg.sv @@
package hhlv_pkg;

    localparam int BYTE_W   = 8;
    localparam int VERD_W   = 3;
    localparam int CODE_W   = 10;
    localparam int PIDX_W   = 3;
    localparam int PREFIX_N = 5;

    // Verdict codes
    typedef enum logic [VERD_W-1:0] {
        VERD_STATUS   = 3'd0,
        VERD_HEADER   = 3'd1,
        VERD_NO_COLON = 3'd2,
        VERD_BAD_NAME = 3'd3,
        VERD_BAD_VAL  = 3'd4
    } verdict_t;

    // Position in the status-line grammar
    typedef enum logic [3:0] {
        PH_PREFIX = 4'd0,
        PH_MAJOR  = 4'd1,
        PH_MINOR  = 4'd2,
        PH_C1     = 4'd3,
        PH_C2     = 4'd4,
        PH_C3     = 4'd5,
        PH_SP     = 4'd6,
        PH_REST   = 4'd7,
        PH_FAIL   = 4'd8
    } phase_t;

    // Token tracking flags for name and value
    typedef struct packed {
        logic bad;
        logic pend;
        logic token;
    } tok_flags_t;

    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_UNDER = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;

    // Lowercase "http/" prefix, one byte per position
    function automatic logic [BYTE_W-1:0] prefix_char(input logic [PIDX_W-1:0] idx);
        logic [BYTE_W-1:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h68;
            3'd1:    ch = 8'h74;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h70;
            3'd4:    ch = 8'h2F;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_upper(input logic [BYTE_W-1:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_alnum(input logic [BYTE_W-1:0] c);
        return is_digit(c) || is_upper(c) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_print(input logic [BYTE_W-1:0] c);
        return (c >= 8'h20) && (c <= 8'h7E);
    endfunction

    function automatic logic is_ws(input logic [BYTE_W-1:0] c);
        return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

endpackage

@@ rtl/core/http_header_line_validator.sv @@
// HTTP header line validator.
// Input channel: one line byte per transfer (line_byte, final_byte set on the
// last byte), handshake line_valid / line_stall. Output channel: one verdict
// per line (verdict, status_value, status_rejected), handshake result_valid /
// result_stall. Bytes not flagged final produce no result.
// Throughput: one byte per cycle, sustained, with no gap between lines, except
// while a final byte waits on a full result register that the receiver stalls.
// A byte goes first into an input register; from there it updates the parser
// state and, for a final byte, loads the result register that drives the verdict.
// The parser state is a few small registers advanced by one short step of
// logic per byte; that single step sets the one-byte-per-cycle rate.
// Reset clears the parser state and the input and result valid bits.
// While the receiver stalls, the verdict holds; non-final bytes keep flowing,
// and only a final byte waits in the input register, which then stalls the
// sender until the result register frees up.
module http_header_line_validator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          line_valid,
    output logic                          line_stall,
    input  logic [hhlv_pkg::BYTE_W-1:0]   line_byte,
    input  logic                          final_byte,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [hhlv_pkg::VERD_W-1:0]   verdict,
    output logic [hhlv_pkg::CODE_W-1:0]   status_value,
    output logic                          status_rejected
);
    import hhlv_pkg::*;

    // Input register
    logic                 stg_valid_reg, stg_valid_next;
    logic [BYTE_W-1:0]    stg_byte_reg;
    logic                 stg_final_reg;

    // Parser state
    phase_t               phase_reg, phase_next;
    logic [PIDX_W-1:0]    pidx_reg, pidx_next;
    logic [CODE_W-1:0]    code_reg, code_next;
    logic                 colon_reg, colon_next;
    tok_flags_t           name_reg, name_next;
    tok_flags_t           val_reg, val_next;

    // Result register
    logic                 res_valid_reg, res_valid_next;
    verdict_t             verd_reg, verd_next;
    logic [CODE_W-1:0]    sval_reg, sval_next;
    logic                 srej_reg, srej_next;

    logic                 advance;
    logic                 in_xfer;
    logic                 res_load;
    logic [BYTE_W-1:0]    c;
    logic [BYTE_W-1:0]    lc;
    logic [CODE_W-1:0]    code_mul;
    phase_t               ph_step;
    logic [PIDX_W-1:0]    pidx_step;
    logic [CODE_W-1:0]    code_step;
    logic                 colon_step;
    tok_flags_t           name_step;
    tok_flags_t           val_step;

    // Handshake control
    assign advance    = stg_valid_reg && (!stg_final_reg || !res_valid_reg || !result_stall);
    assign line_stall = stg_valid_reg && !advance;
    assign in_xfer    = line_valid && !line_stall;
    assign res_load   = advance && stg_final_reg;

    assign c        = stg_byte_reg;
    assign lc       = is_upper(c) ? (c + 8'd32) : c;
    assign code_mul = (code_reg << 3) + (code_reg << 1);

    // Status grammar step
    always_comb
    begin
        ph_step   = phase_reg;
        pidx_step = pidx_reg;
        code_step = code_reg;
        unique case (phase_reg)
            PH_PREFIX:
            begin
                if ((pidx_reg < PIDX_W'(PREFIX_N)) && (lc == prefix_char(pidx_reg)))
                begin
                    pidx_step = pidx_reg + 3'd1;
                    if (pidx_reg == PIDX_W'(PREFIX_N - 1))
                    begin
                        ph_step = PH_MAJOR;
                    end
                end
                else
                begin
                    ph_step = PH_FAIL;
                end
            end
            PH_MAJOR:
            begin
                if (!is_digit(c))
                begin
                    ph_step = (c == CH_DOT) ? PH_MINOR : PH_FAIL;
                end
            end
            PH_MINOR:
            begin
                if (!is_digit(c))
                begin
                    ph_step = (c == CH_SPACE) ? PH_C1 : PH_FAIL;
                end
            end
            PH_C1, PH_C2, PH_C3:
            begin
                if (is_digit(c))
                begin
                    code_step = code_mul + CODE_W'(c - 8'h30);
                    ph_step   = phase_t'(phase_reg + 4'd1);
                end
                else
                begin
                    ph_step = PH_FAIL;
                end
            end
            PH_SP:
            begin
                ph_step = (c == CH_SPACE) ? PH_REST : PH_FAIL;
            end
            PH_REST:
            begin
                if (!is_print(c))
                begin
                    ph_step = PH_FAIL;
                end
            end
            default:
            begin
                ph_step = PH_FAIL;
            end
        endcase
    end

    // Header name / value step
    always_comb
    begin
        colon_step = colon_reg;
        name_step  = name_reg;
        val_step   = val_reg;
        if (!colon_reg)
        begin
            if (c == CH_COLON)
            begin
                colon_step = 1'b1;
            end
            else if (is_ws(c))
            begin
                if (name_reg.token)
                begin
                    name_step.pend = 1'b1;
                end
            end
            else
            begin
                if (name_reg.pend || !(is_alnum(c) || (c == CH_DASH) || (c == CH_UNDER)))
                begin
                    name_step.bad = 1'b1;
                end
                name_step.token = 1'b1;
            end
        end
        else
        begin
            if (is_ws(c))
            begin
                if (val_reg.token && !is_print(c))
                begin
                    val_step.pend = 1'b1;
                end
            end
            else
            begin
                if (val_reg.pend || !is_print(c))
                begin
                    val_step.bad = 1'b1;
                end
                val_step.token = 1'b1;
            end
        end
    end

    // Next state: line end returns everything to the start
    always_comb
    begin
        phase_next = phase_reg;
        pidx_next  = pidx_reg;
        code_next  = code_reg;
        colon_next = colon_reg;
        name_next  = name_reg;
        val_next   = val_reg;
        if (advance)
        begin
            if (stg_final_reg)
            begin
                phase_next = PH_PREFIX;
                pidx_next  = '0;
                code_next  = '0;
                colon_next = 1'b0;
                name_next  = '0;
                val_next   = '0;
            end
            else
            begin
                phase_next = ph_step;
                pidx_next  = pidx_step;
                code_next  = code_step;
                colon_next = colon_step;
                name_next  = name_step;
                val_next   = val_step;
            end
        end
    end

    // Verdict from the stepped state
    always_comb
    begin
        sval_next = '0;
        srej_next = 1'b0;
        if (ph_step == PH_REST)
        begin
            verd_next = VERD_STATUS;
            sval_next = code_step;
        end
        else
        begin
            srej_next = (pidx_step == PIDX_W'(PREFIX_N));
            priority if (!colon_step)
            begin
                verd_next = VERD_NO_COLON;
            end
            else if (name_step.bad)
            begin
                verd_next = VERD_BAD_NAME;
            end
            else if (val_step.bad)
            begin
                verd_next = VERD_BAD_VAL;
            end
            else
            begin
                verd_next = VERD_HEADER;
            end
        end
    end

    // Valid bits
    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        if (in_xfer)
        begin
            stg_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stg_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            phase_reg     <= PH_PREFIX;
            pidx_reg      <= '0;
            code_reg      <= '0;
            colon_reg     <= 1'b0;
            name_reg      <= '0;
            val_reg       <= '0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
            res_valid_reg <= res_valid_next;
            phase_reg     <= phase_next;
            pidx_reg      <= pidx_next;
            code_reg      <= code_next;
            colon_reg     <= colon_next;
            name_reg      <= name_next;
            val_reg       <= val_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            stg_byte_reg  <= line_byte;
            stg_final_reg <= final_byte;
        end
        if (res_load)
        begin
            verd_reg <= verd_next;
            sval_reg <= sval_next;
            srej_reg <= srej_next;
        end
    end

    assign result_valid    = res_valid_reg;
    assign verdict         = verd_reg;
    assign status_value    = sval_reg;
    assign status_rejected = srej_reg;

endmodule

@@ rtl/core/hhlv_checker.sv @@
module hhlv_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          line_valid,
    input  logic                          line_stall,
    input  logic                          final_byte,
    input  logic                          result_valid,
    input  logic                          result_stall,
    input  logic [hhlv_pkg::VERD_W-1:0]   verdict,
    input  logic [hhlv_pkg::CODE_W-1:0]   status_value,
    input  logic                          status_rejected
);
    import hhlv_pkg::*;

    // Held result stays put while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(verdict)
        && $stable(status_value) && $stable(status_rejected))
        else $error("result changed while stalled");

    // Only status lines carry a code
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (verdict != VERD_STATUS) |-> status_value == '0)
        else $error("status code on a non-status verdict");

    // An accepted status line is never flagged rejected
    a_rej: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (verdict == VERD_STATUS) |-> !status_rejected)
        else $error("status line flagged rejected");

    // Status codes are at most 999 and verdicts stay within the defined codes
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (status_value <= CODE_W'(999)) && (verdict <= VERD_BAD_VAL))
        else $error("result out of range");

    // A fresh verdict traces back to a final byte's transfer
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(line_valid && !line_stall && final_byte, 2))
        else $error("result without cause");

endmodule

bind http_header_line_validator hhlv_checker u_hhlv_checker (.*);

@@ tb/http_header_line_validator_tb.sv @@
module http_header_line_validator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hhlv_pkg::*;

    // Cycles with no transfer on either channel before the run is abandoned
    localparam int QUIET_LIMIT = 2000;
    // Random stimulus length, and where idling stops
    localparam int RANDOM_BYTES = 1700;
    localparam int CALM_FROM    = 1450;
    // Line at which the sender waits for all verdicts to drain
    localparam int DRAIN_LINE   = 40;
    localparam int DIR_ROWS     = 27;

    // Lowercase status prefix, first character in the top byte
    localparam logic [39:0] HTTP_TAG = "http/";

    typedef struct {
        verdict_t          verdict;
        logic [CODE_W-1:0] code;
        logic              rej;
    } line_verdict_t;

    // One directed byte; the verdict is typed in only where typed is set
    typedef struct packed {
        logic [BYTE_W-1:0] b;
        logic              fin;
        logic              typed;
        verdict_t          v;
        logic [CODE_W-1:0] code;
        logic              rej;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 line_valid = 1'b0;
    logic                 line_stall;
    logic [BYTE_W-1:0]    line_byte = '0;
    logic                 final_byte = 1'b0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic [VERD_W-1:0]    verdict;
    logic [CODE_W-1:0]    status_value;
    logic                 status_rejected;

    // Parser copy kept by the testbench
    phase_t               grammar_pos;
    logic [PIDX_W-1:0]    tag_matched;
    logic [CODE_W-1:0]    code_sum;
    logic                 past_colon;
    tok_flags_t           name_st;
    tok_flags_t           value_st;

    line_verdict_t        pending_verdicts[$];
    line_verdict_t        head_verdict;
    logic [BYTE_W-1:0]    line_buf[$];
    int                   errors = 0;
    int                   bytes_sent = 0;
    int                   quiet_cycles = 0;
    int                   stall_left = 0;
    bit                   idle_on = 1'b1;

    // Directed lines: a status line with the top code, an empty header,
    // a bad name hiding a bad value, a bad value after a later colon,
    // and a bare prefix that fails the status syntax
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{8'h68, 1'b0, 1'b0, VERD_STATUS,   10'd0,   1'b0},  // h
        '{8'h54, 1'b0, 1'b0, VERD_STATUS,   10'd0,   1'b0},  // T
        '{8'h74, 1'b0, 1'b0, VERD_STATUS,   10'd0,   1'b0},  // t
        '{8'h50, 1'b0, 1'b0, VERD_STATUS,   10'd0,   1'b0},  // P
        '{8'h2F, 1'b0, 1'b0, VERD_STATUS,   10'd0,   1'b0},  // /
        '{8'h2E, 1'b0, 1'b0, VERD_STATUS,   10'd0,   1'b0},  // .
        '{8'h20, 1'b0, 1'b0, VERD_STATUS,   10'd0,   1'b0},
        '{8'h39, 1'b0, 1'b0, VERD_STATUS,   10'd0,   1'b0},  // 9
        '{8'h39, 1'b0, 1'b0, VERD_STATUS,   10'd0,   1'b0},  // 9
        '{8'h39, 1'b0, 1'b0, VERD_STATUS,   10'd0,   1'b0},  // 9
        '{8'h20, 1'b1, 1'b1, VERD_STATUS,   10'd999, 1'b0},
        '{8'h3A, 1'b1, 1'b1, VERD_HEADER,   10'd0,   1'b0},  // :
        '{8'h61, 1'b0, 1'b0, VERD_STATUS,   10'd0,   1'b0},  // a
        '{8'h20, 1'b0, 1'b0, VERD_STATUS,   10'd0,   1'b0},
        '{8'h62, 1'b0, 1'b0, VERD_STATUS,   10'd0,   1'b0},  // b
        '{8'h3A, 1'b0, 1'b0, VERD_STATUS,   10'd0,   1'b0},  // :
        '{8'hFF, 1'b1, 1'b1, VERD_BAD_NAME, 10'd0,   1'b0},
        '{8'h3A, 1'b0, 1'b0, VERD_STATUS,   10'd0,   1'b0},  // :
        '{8'h61, 1'b0, 1'b0, VERD_STATUS,   10'd0,   1'b0},  // a
        '{8'h20, 1'b0, 1'b0, VERD_STATUS,   10'd0,   1'b0},
        '{8'h3A, 1'b0, 1'b0, VERD_STATUS,   10'd0,   1'b0},  // :
        '{8'h00, 1'b1, 1'b0, VERD_STATUS,   10'd0,   1'b0},
        '{8'h48, 1'b0, 1'b0, VERD_STATUS,   10'd0,   1'b0},  // H
        '{8'h54, 1'b0, 1'b0, VERD_STATUS,   10'd0,   1'b0},  // T
        '{8'h54, 1'b0, 1'b0, VERD_STATUS,   10'd0,   1'b0},  // T
        '{8'h50, 1'b0, 1'b0, VERD_STATUS,   10'd0,   1'b0},  // P
        '{8'h2F, 1'b1, 1'b1, VERD_NO_COLON, 10'd0,   1'b1}   // /
    };

    http_header_line_validator i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .line_valid      (line_valid),
        .line_stall      (line_stall),
        .line_byte       (line_byte),
        .final_byte      (final_byte),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .verdict         (verdict),
        .status_value    (status_value),
        .status_rejected (status_rejected)
    );

    always #2 clk = ~clk;

    // Character classes
    function automatic bit ch_num(input logic [BYTE_W-1:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic bit ch_cap(input logic [BYTE_W-1:0] c);
        return c >= 8'h41 && c <= 8'h5A;
    endfunction

    function automatic bit ch_tokenable(input logic [BYTE_W-1:0] c);
        return ch_num(c) || ch_cap(c) || (c >= 8'h61 && c <= 8'h7A)
            || c == CH_DASH || c == CH_UNDER;
    endfunction

    function automatic bit ch_visible(input logic [BYTE_W-1:0] c);
        return c >= 8'h20 && c <= 8'h7E;
    endfunction

    function automatic bit ch_blank(input logic [BYTE_W-1:0] c);
        return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [BYTE_W-1:0] tag_char(input int idx);
        return HTTP_TAG[8*(4-idx) +: 8];
    endfunction

    task automatic clear_parser();
        grammar_pos = PH_PREFIX;
        tag_matched = '0;
        code_sum    = '0;
        past_colon  = 1'b0;
        name_st     = '0;
        value_st    = '0;
    endtask

    // Advance the parser copy by one byte; a final byte yields a verdict
    task automatic parse_byte(input logic [BYTE_W-1:0] c, input logic fin,
                              output bit got, output line_verdict_t res);
        logic [BYTE_W-1:0] lc;
        got         = 1'b0;
        res.verdict = VERD_STATUS;
        res.code    = '0;
        res.rej     = 1'b0;

        // status-line grammar
        case (grammar_pos)
            PH_PREFIX: begin
                lc = ch_cap(c) ? c + 8'd32 : c;
                if (tag_matched < PREFIX_N && lc == tag_char(tag_matched)) begin
                    tag_matched = tag_matched + 1'b1;
                    if (tag_matched == PREFIX_N)
                        grammar_pos = PH_MAJOR;
                end
                else
                    grammar_pos = PH_FAIL;
            end
            PH_MAJOR:
                if (!ch_num(c))
                    grammar_pos = (c == CH_DOT) ? PH_MINOR : PH_FAIL;
            PH_MINOR:
                if (!ch_num(c))
                    grammar_pos = (c == CH_SPACE) ? PH_C1 : PH_FAIL;
            PH_C1, PH_C2, PH_C3:
                if (ch_num(c)) begin
                    code_sum    = CODE_W'(code_sum * 10 + (c - 8'h30));
                    grammar_pos = phase_t'(grammar_pos + 1'b1);
                end
                else
                    grammar_pos = PH_FAIL;
            PH_SP:
                grammar_pos = (c == CH_SPACE) ? PH_REST : PH_FAIL;
            PH_REST:
                if (!ch_visible(c))
                    grammar_pos = PH_FAIL;
            default:
                grammar_pos = PH_FAIL;
        endcase

        // header name / value tracking
        if (!past_colon) begin
            if (c == CH_COLON)
                past_colon = 1'b1;
            else if (ch_blank(c)) begin
                if (name_st.token)
                    name_st.pend = 1'b1;
            end
            else begin
                if (name_st.pend || !ch_tokenable(c))
                    name_st.bad = 1'b1;
                name_st.token = 1'b1;
            end
        end
        else begin
            if (ch_blank(c)) begin
                if (value_st.token && !ch_visible(c))
                    value_st.pend = 1'b1;
            end
            else begin
                if (value_st.pend || !ch_visible(c))
                    value_st.bad = 1'b1;
                value_st.token = 1'b1;
            end
        end

        if (fin) begin
            got = 1'b1;
            if (grammar_pos == PH_REST)
                res.code = code_sum;
            else begin
                res.rej = (tag_matched == PREFIX_N);
                if (!past_colon)
                    res.verdict = VERD_NO_COLON;
                else if (name_st.bad)
                    res.verdict = VERD_BAD_NAME;
                else if (value_st.bad)
                    res.verdict = VERD_BAD_VAL;
                else
                    res.verdict = VERD_HEADER;
            end
            clear_parser();
        end
    endtask

    // Offer one byte, wait for its transfer, then record the expected verdict
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin,
                             input logic use_typed, input verdict_t tv,
                             input logic [CODE_W-1:0] tcode, input logic trej);
        bit            got;
        line_verdict_t res;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            line_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        line_valid <= 1'b1;
        line_byte  <= b;
        final_byte <= fin;
        do
            @(posedge clk);
        while (line_stall !== 1'b0);
        bytes_sent++;
        parse_byte(b, fin, got, res);
        if (got) begin
            if (use_typed) begin
                res.verdict = tv;
                res.code    = tcode;
                res.rej     = trej;
            end
            pending_verdicts.push_back(res);
        end
    endtask

    function automatic logic [BYTE_W-1:0] pick_blank();
        case ($urandom_range(0, 5))
            0:       return 8'h09;
            1:       return 8'h0A;
            2:       return 8'h0B;
            3:       return 8'h0C;
            4:       return 8'h0D;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pick_token();
        int k;
        k = $urandom_range(0, 63);
        if (k < 26)
            return 8'(8'h41 + k);
        else if (k < 52)
            return 8'(8'h61 + k - 26);
        else if (k < 62)
            return 8'(8'h30 + k - 52);
        else if (k == 62)
            return CH_DASH;
        else
            return CH_UNDER;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_digit();
        return 8'(8'h30 + $urandom_range(0, 9));
    endfunction

    function automatic logic [BYTE_W-1:0] pick_visible();
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    // Build one random line: mostly well-formed status or header lines,
    // some of them damaged, the rest raw noise
    task automatic gen_line();
        int kind;
        int pos;
        int keep;
        logic [BYTE_W-1:0] ch;
        line_buf.delete();
        kind = $urandom_range(0, 19);
        if (kind < 7) begin
            for (int i = 0; i < PREFIX_N; i++) begin
                ch = tag_char(i);
                if (ch >= 8'h61 && $urandom_range(0, 1))
                    ch = ch - 8'd32;
                line_buf.push_back(ch);
            end
            repeat ($urandom_range(0, 3)) line_buf.push_back(pick_digit());
            line_buf.push_back(CH_DOT);
            repeat ($urandom_range(0, 3)) line_buf.push_back(pick_digit());
            line_buf.push_back(CH_SPACE);
            repeat (3) line_buf.push_back(pick_digit());
            line_buf.push_back(CH_SPACE);
            repeat ($urandom_range(0, 6)) line_buf.push_back(pick_visible());
        end
        else if (kind < 16) begin
            repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
            repeat ($urandom_range(0, 6)) line_buf.push_back(pick_token());
            repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
            line_buf.push_back(CH_COLON);
            repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
            repeat ($urandom_range(0, 8)) line_buf.push_back(pick_visible());
            repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
        end
        else begin
            repeat ($urandom_range(1, 10)) line_buf.push_back(8'($urandom_range(0, 255)));
        end

        // damage about a third of the structured lines
        if (kind < 16 && $urandom_range(0, 2) == 0) begin
            pos = $urandom_range(0, line_buf.size() - 1);
            case ($urandom_range(0, 2))
                0: line_buf[pos] = 8'($urandom_range(0, 255));
                1: begin
                    keep = pos + 1;
                    while (line_buf.size() > keep)
                        void'(line_buf.pop_back());
                end
                default: line_buf.insert(pos, pick_blank());
            endcase
        end
    endtask

    // Stimulus
    initial begin
        int line_no;
        clear_parser();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_byte(dir_rows[i].b, dir_rows[i].fin, dir_rows[i].typed,
                      dir_rows[i].v, dir_rows[i].code, dir_rows[i].rej);

        bytes_sent = 0;
        line_no    = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            gen_line();
            for (int i = 0; i < line_buf.size(); i++)
                send_byte(line_buf[i], i == line_buf.size() - 1, 1'b0,
                          VERD_STATUS, '0, 1'b0);
            line_no++;
            if (bytes_sent >= CALM_FROM)
                idle_on = 1'b0;
            // hold the sender until every verdict is out
            if (line_no == DRAIN_LINE) begin
                line_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_verdicts.size() != 0);
            end
        end
        line_valid <= 1'b0;

        // drain, then wait on for stray verdicts
        do
            @(posedge clk);
        while (pending_verdicts.size() != 0);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Receiver stall bursts
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            result_stall <= 1'b1;
        end
        else if (rst_n && idle_on && $urandom_range(0, 4) == 0) begin
            stall_left   <= $urandom_range(0, 5);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // Verdict check against the oldest expectation
    always @(posedge clk) begin
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected verdict %0d code %0d rejected %0b",
                         $time, verdict, status_value, status_rejected);
                errors++;
            end
            else begin
                head_verdict = pending_verdicts.pop_front();
                if (verdict !== head_verdict.verdict) begin
                    $display("%0t: verdict expected %0d actual %0d",
                             $time, head_verdict.verdict, verdict);
                    errors++;
                end
                if (status_value !== head_verdict.code) begin
                    $display("%0t: status_value expected %0d actual %0d",
                             $time, head_verdict.code, status_value);
                    errors++;
                end
                if (status_rejected !== head_verdict.rej) begin
                    $display("%0t: status_rejected expected %0b actual %0b",
                             $time, head_verdict.rej, status_rejected);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer
    always @(posedge clk) begin
        if ((line_valid && line_stall === 1'b0) ||
            (result_valid === 1'b1 && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: watchdog timeout, %0d verdicts outstanding",
                     $time, pending_verdicts.size());
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

@@ sim.f @@
rtl/core/hhlv_pkg.sv
rtl/core/http_header_line_validator.sv
rtl/core/hhlv_checker.sv
tb/http_header_line_validator_tb.sv
